[design/srcfd_pkg.sv]
// Shared types, codes and helper functions of the serial relay command frame decoder.
package srcfd_pkg;

	localparam int FRAME_LEN = 8;
	localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
	localparam int QUEUE_DEPTH = 4;

	// Step counter of the back end: step 0 is the echo, steps 1 to FRAME_LEN the report.
	localparam int STEP_W = $clog2(FRAME_LEN + 1);
	localparam logic [STEP_W-1:0] STEP_ECHO = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_FIRST_REPORT = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAME_LEN);

	// Frame markers.
	localparam logic [7:0] HEAD0 = 8'hFF;
	localparam logic [7:0] HEAD1 = 8'hFE;
	localparam logic [7:0] TAIL0 = 8'hFD;
	localparam logic [7:0] TAIL1 = 8'hFC;
	localparam logic [7:0] REPLY_TAIL = 8'hFD;
	localparam logic [7:0] REPLY_PAD = 8'h00;

	// Relay levels, active low.
	localparam logic [7:0] RELAYS_ALL_OFF = 8'hFF;
	localparam logic [7:0] RELAYS_ALL_ON = 8'h00;
	localparam logic [7:0] INPUT_RESET_LEVEL = 8'hFF;

	// Command codes.
	localparam logic [7:0] CMD_ALL_ON = 8'hFF;
	localparam logic [7:0] CMD_ALL_OFF = 8'h00;
	localparam logic [7:0] CMD_CH_ON_FIRST = 8'h01;
	localparam logic [7:0] CMD_CH_ON_LAST = 8'h08;
	localparam logic [7:0] CMD_CH_OFF_FIRST = 8'hFE;
	localparam logic [7:0] CMD_CH_OFF_LAST = 8'hF7;
	localparam logic [7:0] CMD_INVERT = 8'h11;
	localparam logic [7:0] CMD_REPORT_INPUT = 8'h55;
	localparam logic [7:0] CMD_REPORT_RELAY = 8'hAA;

	// Action codes of an input item.
	localparam logic ACT_SERIAL = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// One unit of work handed from the front end to the back end.
	typedef struct packed {
		logic       has_echo;
		logic [7:0] echo;
		logic       has_report;
		logic [7:0] status;
		logic [7:0] relay;
	} job_t;

	// Byte of the reply frame FF FE status 00 00 00 FD FD at a given position.
	function automatic logic [7:0] report_byte(input logic [FRAME_IDX_W-1:0] pos,
		input logic [7:0] status);
		logic [7:0] b;
		case (pos)
			FRAME_IDX_W'(0): b = HEAD0;
			FRAME_IDX_W'(1): b = HEAD1;
			FRAME_IDX_W'(2): b = status;
			FRAME_IDX_W'(FRAME_LEN - 2): b = REPLY_TAIL;
			FRAME_IDX_W'(FRAME_LEN - 1): b = REPLY_TAIL;
			default: b = REPLY_PAD;
		endcase
		return b;
	endfunction

endpackage

[design/serial_relay_command_frame_decoder_core.sv]
// Top level of the serial relay command frame decoder: front end, job queue and back end.
//
//   Channel   Handshake         Payload
//   input     push / full       action, rx_byte, input_port
//   result    pop / empty       tx_byte, last, relay_outputs
//
// An item is taken in any cycle in which full is low; frame collection, command decode and
// the relay update all happen at the accepting edge. Each item yields zero to nine results
// (an echo, an 8-byte reply, or both), sent one per cycle while pop is high, which sets the
// sustained rate. An item's first result passes the job queue, then the back end register.
// full rises only when all QUEUE_DEPTH job slots are taken, so result stalls reach the input.
// Reset (arst_n low) clears the frame, sets all relays off and the input level to FF.
module serial_relay_command_frame_decoder_core #(
	parameter int QUEUE_DEPTH = srcfd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [7:0] rx_byte,
	input  logic [7:0] input_port,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tx_byte,
	output logic       last,
	output logic [7:0] relay_outputs
);

	logic            accept;
	logic            job_valid;
	srcfd_pkg::job_t job;
	logic            q_valid;
	logic            q_pop;
	srcfd_pkg::job_t q_job;

	// An item enters the front end whenever the queue has room for what it may produce.
	assign accept = push && !full;

	srcfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.rx_byte    (rx_byte),
		.input_port (input_port),
		.job_valid  (job_valid),
		.job        (job)
	);

	srcfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_valid),
		.wr_job (job),
		.full   (full),
		.rd_en  (q_pop),
		.valid  (q_valid),
		.rd_job (q_job)
	);

	// The back end holds one job and walks through its results.
	srcfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (q_job),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.tx_byte       (tx_byte),
		.last          (last),
		.relay_outputs (relay_outputs)
	);

`ifndef SYNTHESIS
	// A job is never offered to a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !full)
		else $error("job written into a full queue");

	// Results of one item follow each other without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> !empty)
		else $error("result stream of an item broke off");

	// The relay level is the same on every result of one item.
	a_relay_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> $stable(relay_outputs))
		else $error("relay level changed within an item");

	// Jobs are only taken from the queue when it holds one.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end took a job from an empty queue");
`endif

endmodule

[design/srcfd_front.sv]
// Front end: takes input items, collects frames, runs commands and builds jobs.
module srcfd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 action,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           input_port,
	output logic                 job_valid,
	output srcfd_pkg::job_t      job
);

	logic [srcfd_pkg::FRAME_IDX_W-1:0] frame_cnt_q;
	logic [srcfd_pkg::FRAME_IDX_W-1:0] frame_cnt_d;
	logic [7:0] buf_q [srcfd_pkg::FRAME_LEN];
	logic [7:0] buf_d [srcfd_pkg::FRAME_LEN];
	logic [7:0] relay_q;
	logic [7:0] relay_d;
	logic [7:0] last_in_q;
	logic       complete;
	logic       frame_ok;
	logic       changed;
	logic       cmd_report;
	logic [7:0] cmd_status;
	logic [7:0] cmd;
	logic [7:0] off_dist;
	logic [7:0] on_dist;

	always_comb begin
		for (int i = 0; i < srcfd_pkg::FRAME_LEN; i++) begin
			buf_d[i] = (frame_cnt_q == srcfd_pkg::FRAME_IDX_W'(i)) ? rx_byte : buf_q[i];
		end
	end

	assign complete = (frame_cnt_q == srcfd_pkg::FRAME_IDX_W'(srcfd_pkg::FRAME_LEN - 1));
	assign frame_ok = complete && buf_d[0] == srcfd_pkg::HEAD0 && buf_d[1] == srcfd_pkg::HEAD1
		&& buf_d[srcfd_pkg::FRAME_LEN-2] == srcfd_pkg::TAIL0
		&& buf_d[srcfd_pkg::FRAME_LEN-1] == srcfd_pkg::TAIL1;
	assign frame_cnt_d = (complete || buf_d[0] != srcfd_pkg::HEAD0)
		? '0 : frame_cnt_q + srcfd_pkg::FRAME_IDX_W'(1);
	assign changed = (input_port != last_in_q);

	assign cmd = buf_d[2];
	assign on_dist = cmd - srcfd_pkg::CMD_CH_ON_FIRST;
	assign off_dist = srcfd_pkg::CMD_CH_OFF_FIRST - cmd;

	// Command decode of a good frame; relay_d is the level after this item.
	always_comb begin
		relay_d = relay_q;
		cmd_report = 1'b0;
		cmd_status = relay_q;
		if (action == srcfd_pkg::ACT_SERIAL && frame_ok) begin
			case (cmd)
				srcfd_pkg::CMD_ALL_ON: relay_d = srcfd_pkg::RELAYS_ALL_ON;
				srcfd_pkg::CMD_ALL_OFF: relay_d = srcfd_pkg::RELAYS_ALL_OFF;
				srcfd_pkg::CMD_INVERT: relay_d = ~relay_q;
				srcfd_pkg::CMD_REPORT_INPUT: begin
					cmd_report = 1'b1;
					cmd_status = input_port;
				end
				srcfd_pkg::CMD_REPORT_RELAY: begin
					cmd_report = 1'b1;
					cmd_status = relay_q;
				end
				default: begin
					if (cmd inside {[srcfd_pkg::CMD_CH_ON_FIRST:srcfd_pkg::CMD_CH_ON_LAST]}) begin
						relay_d = relay_q & ~(8'h01 << on_dist[2:0]);
					end else if (cmd inside
						{[srcfd_pkg::CMD_CH_OFF_LAST:srcfd_pkg::CMD_CH_OFF_FIRST]}) begin
						relay_d = relay_q | (8'h01 << off_dist[2:0]);
					end
				end
			endcase
		end
	end

	always_comb begin
		job.relay = relay_d;
		if (action == srcfd_pkg::ACT_SERIAL) begin
			job.has_echo = 1'b1;
			job.echo = rx_byte;
			job.has_report = cmd_report;
			job.status = cmd_status;
			job_valid = accept;
		end else begin
			job.has_echo = 1'b0;
			job.echo = rx_byte;
			job.has_report = 1'b1;
			job.status = input_port;
			job_valid = accept && changed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			relay_q <= srcfd_pkg::RELAYS_ALL_OFF;
			last_in_q <= srcfd_pkg::INPUT_RESET_LEVEL;
			for (int i = 0; i < srcfd_pkg::FRAME_LEN; i++) begin
				buf_q[i] <= '0;
			end
		end else if (accept) begin
			if (action == srcfd_pkg::ACT_SERIAL) begin
				frame_cnt_q <= frame_cnt_d;
				relay_q <= relay_d;
				for (int i = 0; i < srcfd_pkg::FRAME_LEN; i++) begin
					buf_q[i] <= buf_d[i];
				end
			end else begin
				last_in_q <= input_port;
			end
		end
	end

endmodule

[design/srcfd_queue.sv]
// Short job queue between the front end and the back end.
module srcfd_queue #(
	parameter int DEPTH = srcfd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  srcfd_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output logic            valid,
	output srcfd_pkg::job_t rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	srcfd_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[design/srcfd_back.sv]
// Back end: plays out the echo and reply bytes of each job, one result per cycle while pop is high.
module srcfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  srcfd_pkg::job_t q_job,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      tx_byte,
	output logic            last,
	output logic [7:0]      relay_outputs
);

	logic                        busy_q;
	srcfd_pkg::job_t             job_q;
	logic [srcfd_pkg::STEP_W-1:0] step_q;
	logic [srcfd_pkg::STEP_W-1:0] rep_pos;
	logic                        taken;

	assign empty = !busy_q;
	assign taken = busy_q && pop;
	assign rep_pos = step_q - srcfd_pkg::STEP_FIRST_REPORT;
	assign tx_byte = (step_q == srcfd_pkg::STEP_ECHO) ? job_q.echo
		: srcfd_pkg::report_byte(rep_pos[srcfd_pkg::FRAME_IDX_W-1:0], job_q.status);
	assign last = (step_q == srcfd_pkg::STEP_LAST)
		|| (step_q == srcfd_pkg::STEP_ECHO && !job_q.has_report);
	assign relay_outputs = job_q.relay;

	// A new job loads when idle or in the cycle its predecessor's last result leaves.
	assign q_pop = q_valid && (!busy_q || (taken && last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= srcfd_pkg::STEP_ECHO;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			step_q <= q_job.has_echo ? srcfd_pkg::STEP_ECHO : srcfd_pkg::STEP_FIRST_REPORT;
		end else if (taken) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + srcfd_pkg::STEP_W'(1);
			end
		end
	end

endmodule

[verif/serial_relay_command_frame_decoder_core_tb.sv]
// Self-checking testbench of the serial relay command frame decoder core.
module serial_relay_command_frame_decoder_core_tb;

	// A run with no handshake on either side for this many cycles is a hang.
	localparam int STALL_LIMIT = 2000;
	// Cycles left after the last expected result, so stray late results are seen.
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET = 470;

	// One item for the input side: a serial byte or an input port sample.
	typedef struct {
		logic       act;
		logic [7:0] rx;
		logic [7:0] port;
	} host_item_t;

	// One transmitted byte as the block must present it.
	typedef struct {
		logic [7:0] tx;
		logic       last;
		logic [7:0] relay;
	} tx_byte_t;

	// Ways to spoil a command frame on purpose.
	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_HEAD,
		FLAW_TAIL,
		FLAW_CUT
	} frame_flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       action = srcfd_pkg::ACT_SERIAL;
	logic [7:0] rx_byte = 8'h00;
	logic [7:0] input_port = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] tx_byte;
	logic       last;
	logic [7:0] relay_outputs;

	host_item_t host_items[$];
	tx_byte_t   tx_expect[$];

	// Shadow of the decoder state, advanced once per accepted item.
	logic [2:0] frm_cnt = 3'd0;
	logic [7:0] frm_buf[srcfd_pkg::FRAME_LEN];
	logic [7:0] relay_lvl = srcfd_pkg::RELAYS_ALL_OFF;
	logic [7:0] in_lvl = srcfd_pkg::INPUT_RESET_LEVEL;

	// Frame position and input level as the stimulus generator expects them. The
	// generator needs these to start its well-formed frames on a frame boundary
	// and to produce samples that repeat the current level.
	int         gen_cnt = 0;
	logic [7:0] gen_lvl = srcfd_pkg::INPUT_RESET_LEVEL;

	int   errors = 0;
	int   stall_cycles = 0;
	int   items_sent = 0;
	int   idle_pct;
	logic in_taken = 1'b0;

	serial_relay_command_frame_decoder_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.rx_byte(rx_byte),
		.input_port(input_port),
		.empty(empty),
		.pop(pop),
		.tx_byte(tx_byte),
		.last(last),
		.relay_outputs(relay_outputs)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Works out the bytes that one accepted item must produce and queues them in
	// order: the echo first, then the eight-byte reply if there is one.
	task automatic decode_item(input logic act, input logic [7:0] rxb,
		input logic [7:0] inp);
		int         idx;
		int         n;
		int         k;
		bit         complete;
		bit         has_echo;
		bit         has_reply;
		logic [7:0] status;
		logic [7:0] cmd;
		tx_byte_t   e;
		has_echo = 1'b0;
		has_reply = 1'b0;
		status = 8'h00;
		if (act == srcfd_pkg::ACT_SAMPLE) begin
			// Only a change of the input level is reported; the serial byte is ignored.
			if (inp != in_lvl) begin
				in_lvl = inp;
				has_reply = 1'b1;
				status = inp;
			end
		end else begin
			idx = frm_cnt;
			frm_buf[idx] = rxb;
			idx++;
			complete = (idx == srcfd_pkg::FRAME_LEN);
			// Collection starts over when a frame is full or does not open with FF.
			if (complete || frm_buf[0] != srcfd_pkg::HEAD0)
				idx = 0;
			frm_cnt = idx[2:0];
			has_echo = 1'b1;
			if (complete && frm_buf[0] == srcfd_pkg::HEAD0
					&& frm_buf[1] == srcfd_pkg::HEAD1
					&& frm_buf[srcfd_pkg::FRAME_LEN-2] == srcfd_pkg::TAIL0
					&& frm_buf[srcfd_pkg::FRAME_LEN-1] == srcfd_pkg::TAIL1) begin
				cmd = frm_buf[2];
				if (cmd == srcfd_pkg::CMD_ALL_ON) begin
					relay_lvl = srcfd_pkg::RELAYS_ALL_ON;
				end else if (cmd == srcfd_pkg::CMD_ALL_OFF) begin
					relay_lvl = srcfd_pkg::RELAYS_ALL_OFF;
				end else if (cmd >= srcfd_pkg::CMD_CH_ON_FIRST
						&& cmd <= srcfd_pkg::CMD_CH_ON_LAST) begin
					relay_lvl[cmd - srcfd_pkg::CMD_CH_ON_FIRST] = 1'b0;
				end else if (cmd >= srcfd_pkg::CMD_CH_OFF_LAST
						&& cmd <= srcfd_pkg::CMD_CH_OFF_FIRST) begin
					relay_lvl[srcfd_pkg::CMD_CH_OFF_FIRST - cmd] = 1'b1;
				end else if (cmd == srcfd_pkg::CMD_INVERT) begin
					relay_lvl = ~relay_lvl;
				end else if (cmd == srcfd_pkg::CMD_REPORT_INPUT) begin
					// The port is read here but the recorded input level stays as it was.
					has_reply = 1'b1;
					status = inp;
				end else if (cmd == srcfd_pkg::CMD_REPORT_RELAY) begin
					has_reply = 1'b1;
					status = relay_lvl;
				end
			end
		end
		n = (has_echo ? 1 : 0) + (has_reply ? srcfd_pkg::FRAME_LEN : 0);
		k = 0;
		e.relay = relay_lvl;
		if (has_echo) begin
			e.tx = rxb;
			e.last = (k == n - 1);
			tx_expect.push_back(e);
			k++;
		end
		if (has_reply) begin
			for (int j = 0; j < srcfd_pkg::FRAME_LEN; j++) begin
				case (j)
					0: e.tx = srcfd_pkg::HEAD0;
					1: e.tx = srcfd_pkg::HEAD1;
					2: e.tx = status;
					srcfd_pkg::FRAME_LEN - 2, srcfd_pkg::FRAME_LEN - 1:
						e.tx = srcfd_pkg::REPLY_TAIL;
					default: e.tx = srcfd_pkg::REPLY_PAD;
				endcase
				e.last = (k == n - 1);
				tx_expect.push_back(e);
				k++;
			end
		end
	endtask

	task automatic add_serial(input logic [7:0] rxb, input logic [7:0] port);
		host_item_t it;
		it.act = srcfd_pkg::ACT_SERIAL;
		it.rx = rxb;
		it.port = port;
		host_items.push_back(it);
		if (gen_cnt != 0 || rxb == srcfd_pkg::HEAD0)
			gen_cnt = (gen_cnt + 1) % srcfd_pkg::FRAME_LEN;
	endtask

	task automatic add_sample(input logic [7:0] port);
		host_item_t it;
		it.act = srcfd_pkg::ACT_SAMPLE;
		it.rx = 8'($urandom);
		it.port = port;
		host_items.push_back(it);
		gen_lvl = port;
	endtask

	// Queues a command frame FF FE cmd x x x FD FC, spoiled as the flaw says.
	// A partly collected frame is first filled up with zero bytes so that the new
	// frame starts at its first position. Now and then a port sample is slipped
	// between two bytes, which must not disturb the frame.
	task automatic add_frame(input logic [7:0] cmd, input logic [7:0] port,
		input frame_flaw_t flaw);
		logic [7:0] b[srcfd_pkg::FRAME_LEN];
		int         len;
		int         p;
		while (gen_cnt != 0)
			add_serial(srcfd_pkg::REPLY_PAD, 8'($urandom));
		b[0] = srcfd_pkg::HEAD0;
		b[1] = srcfd_pkg::HEAD1;
		b[2] = cmd;
		for (int i = 3; i < srcfd_pkg::FRAME_LEN - 2; i++)
			b[i] = 8'($urandom);
		b[srcfd_pkg::FRAME_LEN-2] = srcfd_pkg::TAIL0;
		b[srcfd_pkg::FRAME_LEN-1] = srcfd_pkg::TAIL1;
		len = srcfd_pkg::FRAME_LEN;
		case (flaw)
			FLAW_HEAD: begin
				p = $urandom_range(0, 1);
				b[p] = b[p] ^ 8'($urandom_range(1, 255));
			end
			FLAW_TAIL: begin
				p = $urandom_range(srcfd_pkg::FRAME_LEN - 2, srcfd_pkg::FRAME_LEN - 1);
				b[p] = b[p] ^ 8'($urandom_range(1, 255));
			end
			FLAW_CUT: len = $urandom_range(1, srcfd_pkg::FRAME_LEN - 1);
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 5)
				add_sample(8'($urandom));
			add_serial(b[i], port);
		end
	endtask

	// Driver. Inputs move only at the falling edge. A new item is put on the
	// ports once the previous one was taken, unless this cycle is an idle one.
	// Between the 200th and 300th item neither side idles, so the block also
	// runs at full rate in both directions for a while.
	always @(negedge clk) begin
		idle_pct = (items_sent >= 200 && items_sent < 300) ? 0 : 35;
		if (arst_n) begin
			if (!push || in_taken) begin
				if (host_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					action <= host_items[0].act;
					rx_byte <= host_items[0].rx;
					input_port <= host_items[0].port;
					void'(host_items.pop_front());
					push <= 1'b1;
					items_sent++;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Monitor. Both handshakes are sampled at the rising edge. A result popped
	// in the same cycle as an item is pushed always belongs to an older item,
	// so the result is checked before the new item is decoded.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (tx_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected result tx_byte %02h", tx_byte));
				end else begin
					if (tx_byte !== tx_expect[0].tx)
						report_mismatch($sformatf("tx_byte got %02h want %02h",
							tx_byte, tx_expect[0].tx));
					if (last !== tx_expect[0].last)
						report_mismatch($sformatf("last got %b want %b",
							last, tx_expect[0].last));
					if (relay_outputs !== tx_expect[0].relay)
						report_mismatch($sformatf("relay_outputs got %02h want %02h",
							relay_outputs, tx_expect[0].relay));
					void'(tx_expect.pop_front());
				end
			end
			if (push && !full)
				decode_item(action, rx_byte, input_port);
			in_taken <= push && !full;
			// Watchdog: any handshake on either side counts as progress.
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("timeout after %0d cycles without progress", STALL_LIMIT);
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [7:0] cmd;
		int         r;
		for (int i = 0; i < srcfd_pkg::FRAME_LEN; i++)
			frm_buf[i] = 8'h00;

		// Directed part. A sample at the reset level gives nothing; a sample of
		// all zeros gives a reply. A lone zero byte is only echoed. Then all relays
		// on, a relay report that must carry status 00, and a frame with a broken
		// tail whose invert command must be ignored.
		add_sample(srcfd_pkg::INPUT_RESET_LEVEL);
		add_sample(8'h00);
		add_serial(8'h00, 8'hFF);
		add_frame(srcfd_pkg::CMD_ALL_ON, 8'hFF, FLAW_NONE);
		add_frame(srcfd_pkg::CMD_REPORT_RELAY, 8'h00, FLAW_NONE);
		add_frame(srcfd_pkg::CMD_INVERT, 8'hFF, FLAW_TAIL);

		// Random part: mostly well-formed frames with every kind of command, and
		// in between spoiled frames, port samples and loose bytes.
		while (host_items.size() < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				case ($urandom_range(0, 8))
					0: cmd = srcfd_pkg::CMD_ALL_ON;
					1: cmd = srcfd_pkg::CMD_ALL_OFF;
					2: cmd = srcfd_pkg::CMD_CH_ON_FIRST + 8'($urandom_range(0, 7));
					3: cmd = srcfd_pkg::CMD_CH_OFF_LAST + 8'($urandom_range(0, 7));
					4: cmd = srcfd_pkg::CMD_INVERT;
					5: cmd = srcfd_pkg::CMD_REPORT_INPUT;
					6: cmd = srcfd_pkg::CMD_REPORT_RELAY;
					default: cmd = 8'($urandom);
				endcase
				if (r < 55)
					add_frame(cmd, 8'($urandom), FLAW_NONE);
				else
					add_frame(cmd, 8'($urandom),
						frame_flaw_t'($urandom_range(FLAW_HEAD, FLAW_CUT)));
			end else if (r < 85) begin
				// Repeat the current level now and then to hit the no-change case.
				if ($urandom_range(0, 99) < 40)
					add_sample(gen_lvl);
				else
					add_sample(8'($urandom));
			end else begin
				add_serial(8'($urandom), 8'($urandom));
			end
		end

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (host_items.size() != 0 || push)
			@(posedge clk);
		while (tx_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tx_expect.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", tx_expect.size()));
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
